// ----- rtl/smf_pkg.sv -----
`timescale 1ns / 1ps
package smf_pkg;
  localparam int MaxOrderDef = 32;
  localparam int SampleW = 24;
  localparam int OrderW = 6;
  localparam int SeenW = 6;
  localparam logic [OrderW-1:0] OrderReset = 6'd5;

  typedef logic signed [SampleW-1:0] sample_t;

  // one queued word from front to back
  typedef struct packed {
    sample_t    sample;
    logic       last;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATHER,
    ST_SORT,
    ST_EMIT
  } back_state_t;
endpackage

// ----- rtl/smf_queue.sv -----
`timescale 1ns / 1ps
module smf_queue
  import smf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic flush,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);
  job_t          mem_r [2];
  logic [1:0]    cnt_r;
  logic          wp_r;
  logic          rp_r;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign pop_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
    if (!rst_n || flush) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- rtl/smf_back.sv -----
`timescale 1ns / 1ps
module smf_back
  import smf_pkg::*;
#(
  parameter int MaxOrder = MaxOrderDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic [OrderW-1:0] order,
  input  logic              q_empty,
  input  job_t              q_job,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output sample_t           out_median_value,
  output logic              out_last_result,
  output logic              out_too_short
);
  localparam int IdxW = $clog2(MaxOrder + 1);
  localparam int AgeW = $clog2(MaxOrder);

  sample_t          hist_r [MaxOrder];
  sample_t          win_r  [MaxOrder];
  logic [SeenW-1:0] seen_r;
  back_state_t      st_r, st_nxt;
  job_t             job_r;
  logic [IdxW-1:0]  len_r, kk_r;
  logic [IdxW-1:0]  gi_r;
  logic [IdxW-1:0]  sp_r;
  logic signed [7:0] p_r, pend_r;
  logic             short_r;
  sample_t          res_r;
  logic             rlast_r, rshort_r, rvalid_r;

  // clamp order
  logic [IdxW-1:0] len_c;
  always_comb begin
    if (order == '0) len_c = IdxW'(1);
    else if (32'(order) > MaxOrder) len_c = IdxW'(MaxOrder);
    else len_c = IdxW'(order);
  end

  // window element fetch
  logic signed [8:0] e_c, idx_c, age_c, n_c;
  sample_t fetch_c;
  always_comb begin
    n_c = 9'(seen_r);
    e_c = 9'(p_r) - 9'(kk_r) + 9'(gi_r);
    idx_c = e_c;
    if (e_c < 0) idx_c = -9'sd1 - e_c;
    else if (job_r.last && e_c > n_c) idx_c = 9'sd2 * (n_c + 9'sd1) - 9'sd1 - e_c;
    if (idx_c > n_c) idx_c = n_c;
    if (idx_c < 0) idx_c = '0;
    age_c = n_c - idx_c;
    if (age_c <= 0) fetch_c = job_r.sample;
    else if (age_c > MaxOrder) fetch_c = hist_r[MaxOrder-1];
    else fetch_c = hist_r[AgeW'(age_c - 9'sd1)];
  end

  // odd-even transposition: one pass per cycle, len passes
  sample_t sorted_c [MaxOrder];
  always_comb begin
    for (int i = 0; i < MaxOrder; i++) sorted_c[i] = win_r[i];
    for (int i = 0; i + 1 < MaxOrder; i++) begin
      if (((i & 1) == int'(sp_r[0])) && (i + 1 < int'(len_r))
          && win_r[i] > win_r[i+1]) begin
        sorted_c[i]   = win_r[i+1];
        sorted_c[i+1] = win_r[i];
      end
    end
  end

  logic [AgeW-1:0] mid_hi, mid_lo;
  logic signed [SampleW:0] sum_c;
  sample_t med_c;
  always_comb begin
    mid_hi = AgeW'(kk_r);
    mid_lo = AgeW'(kk_r - 1'b1);
    sum_c = {win_r[mid_hi][SampleW-1], win_r[mid_hi]}
          + {win_r[mid_lo][SampleW-1], win_r[mid_lo]};
    med_c = len_r[0] ? win_r[mid_hi] : sum_c[SampleW:1];
  end

  logic out_free;
  assign out_free = !rvalid_r || out_ready;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:   if (!q_empty) st_nxt = ST_GATHER;
      ST_GATHER: st_nxt = (p_r > pend_r) ? ST_IDLE
                        : ((gi_r == len_r - 1'b1) ? ST_SORT : ST_GATHER);
      ST_SORT:   if (sp_r == len_r) st_nxt = ST_EMIT;
      ST_EMIT:   if (out_free) st_nxt = ST_GATHER;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (st_r == ST_GATHER) && (p_r > pend_r);
  end

  logic signed [7:0] n8, kk8, first8;
  always_comb begin
    n8 = 8'(seen_r);
    kk8 = 8'(len_c >> 1);
    first8 = n8 - kk8;
    if (first8 < 0) first8 = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      st_r <= ST_IDLE;
      seen_r <= '0;
      rvalid_r <= 1'b0;
      for (int i = 0; i < MaxOrder; i++) hist_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_EMIT && out_free) rvalid_r <= 1'b1;
      else if (out_ready) rvalid_r <= 1'b0;
      case (st_r)
        ST_IDLE: if (!q_empty) begin
          job_r <= q_job;
          len_r <= len_c;
          kk_r  <= len_c >> 1;
          gi_r  <= '0;
          short_r <= (n8 >= 1) && (n8 + 1 < kk8);
          if (q_job.last) begin
            p_r <= first8; pend_r <= n8;
          end else if (n8 >= kk8) begin
            p_r <= n8 - kk8; pend_r <= n8 - kk8;
          end else begin
            p_r <= 8'sd1; pend_r <= 8'sd0;
          end
        end
        ST_GATHER: begin
          if (p_r > pend_r) begin
            if (job_r.last) begin
              seen_r <= '0;
              for (int i = 0; i < MaxOrder; i++) hist_r[i] <= '0;
            end else begin
              for (int i = MaxOrder - 1; i > 0; i--) hist_r[i] <= hist_r[i-1];
              hist_r[0] <= job_r.sample;
              if (seen_r != '1) seen_r <= seen_r + 1'b1;
            end
          end else begin
            win_r[AgeW'(gi_r)] <= fetch_c;
            gi_r <= gi_r + 1'b1;
            sp_r <= '0;
          end
        end
        ST_SORT: if (sp_r != len_r) begin
          for (int i = 0; i < MaxOrder; i++) win_r[i] <= sorted_c[i];
          sp_r <= sp_r + 1'b1;
        end
        ST_EMIT: if (out_free) begin
          res_r    <= med_c;
          rlast_r  <= job_r.last && (p_r == pend_r);
          rshort_r <= job_r.last && short_r;
          p_r  <= p_r + 8'sd1;
          gi_r <= '0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = rvalid_r;
  assign out_median_value = res_r;
  assign out_last_result  = rlast_r;
  assign out_too_short    = rshort_r;
endmodule

// ----- rtl/sliding_median_filter_mirrored.sv -----
`timescale 1ns / 1ps
// Running median over window_order samples (clamped to 1..MaxOrder) with
// half-sample mirror extension. Words enter a two-deep queue; the back end
// gathers the window one element a cycle, sorts it with odd-even
// transposition passes, one per cycle, then emits the result. Each word is
// loaded from the queue before its results and added to the history after
// them; a stalled output holds the emit step. Results lag input by order/2
// and the last word flushes the tail. Writing cfg_window_order restarts
// the signal.
module sliding_median_filter_mirrored
  import smf_pkg::*;
#(
  parameter int MaxOrder = MaxOrderDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sample_t           in_sample,
  input  logic              in_last_sample,
  output logic              out_valid,
  input  logic              out_ready,
  output sample_t           out_median_value,
  output logic              out_last_result,
  output logic              out_too_short,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [OrderW-1:0] cfg_window_order
);
  logic [OrderW-1:0] order_r;
  logic q_full, q_empty, q_pop, cfg_wr;
  job_t q_job, in_job;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_ready  = !q_full;
  assign in_job    = '{sample: in_sample, last: in_last_sample};

  always_ff @(posedge clk) begin
    if (!rst_n) order_r <= OrderReset;
    else if (cfg_wr) order_r <= cfg_window_order;
  end

  smf_queue u_queue (
    .clk, .rst_n, .flush(cfg_wr),
    .push(in_valid && in_ready), .push_job(in_job), .full(q_full),
    .pop(q_pop), .pop_job(q_job), .empty(q_empty)
  );

  smf_back #(.MaxOrder(MaxOrder)) u_back (
    .clk, .rst_n, .clear(cfg_wr), .order(order_r),
    .q_empty, .q_job, .q_pop,
    .out_valid, .out_ready, .out_median_value, .out_last_result, .out_too_short
  );
endmodule

// ----- rtl/smf_checker.sv -----
`timescale 1ns / 1ps
module smf_props
  import smf_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t out_median_value,
  input logic    out_last_result,
  input logic    out_too_short
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("out word dropped");
  a_out_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_median_value))
    else $error("out word changed while waiting");
  a_out_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({out_last_result, out_too_short}))
    else $error("out flags changed while waiting");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind sliding_median_filter_mirrored smf_props u_chk (
  .clk, .rst_n, .out_valid, .out_ready, .out_median_value, .out_last_result,
  .out_too_short
);
